// File: hw/rtl/trc_pkg.sv
// ----------------------------------------------------------------------------
// trc_pkg
// Shared types, constants and helpers of the touch report conditioner.
// ----------------------------------------------------------------------------
package trc_pkg;

  localparam int unsigned ERROR_LIMIT    = 5;
  localparam int unsigned RAW_COORD_BITS = 12;

  localparam int unsigned RAW_W   = 12;
  localparam int unsigned DISP_W  = 10;
  localparam int unsigned PANEL_W = 12;
  localparam int unsigned PROD_W  = RAW_W + DISP_W;
  localparam int unsigned CNT_W   = $clog2(PROD_W);
  localparam int unsigned ERR_W   = 8;
  localparam int unsigned CNTT_W  = 4;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned APB_AW  = 4;
  localparam int unsigned APB_DW  = 32;

  localparam int unsigned RawKeep = (RAW_COORD_BITS < RAW_W) ? RAW_COORD_BITS : RAW_W;
  localparam logic [RAW_W-1:0] RAW_MASK = {RAW_W{1'b1}} >> (RAW_W - RawKeep);

  localparam logic [ERR_W-1:0] ERR_LIMIT_V = ERR_W'(ERROR_LIMIT);
  localparam logic [ERR_W-1:0] ERR_MAX     = {ERR_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    EV_UP   = 2'd0,
    EV_DOWN = 2'd1,
    EV_STOP = 2'd2
  } event_kind_e;

  localparam logic [1:0] REG_DISP_W  = 2'd0;
  localparam logic [1:0] REG_DISP_H  = 2'd1;
  localparam logic [1:0] REG_PANEL_W = 2'd2;
  localparam logic [1:0] REG_PANEL_H = 2'd3;

  localparam logic [DISP_W-1:0]  DISP_W_RST  = DISP_W'(200);
  localparam logic [DISP_W-1:0]  DISP_H_RST  = DISP_W'(228);
  localparam logic [PANEL_W-1:0] PANEL_W_RST = PANEL_W'(390);
  localparam logic [PANEL_W-1:0] PANEL_H_RST = PANEL_W'(450);

  typedef struct packed {
    logic load;
    logic restart;
    logic fail;
    logic lift;
    logic div_start;
    logic sel_y;
    logic save_x;
    logic touch;
    logic emit0;
    logic emit1;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic stopped;
    logic read_ok;
    logic count_zero;
    logic div_done;
    logic ev0_v;
    logic ev1_v;
    logic out_free;
  } sts_t;

  function automatic logic [DISP_W-1:0] clamp_axis(input logic [PROD_W-1:0] q,
                                                   input logic [DISP_W-1:0] disp);
    logic [DISP_W-1:0] bound;
    bound = (disp == '0) ? '0 : disp - DISP_W'(1);
    if (q > PROD_W'(bound)) begin
      return bound;
    end
    return q[DISP_W-1:0];
  endfunction

endpackage

// File: hw/rtl/trc_div.sv
// ----------------------------------------------------------------------------
// trc_div
// Restoring divider, one quotient bit per cycle; divide by zero gives all ones.
// ----------------------------------------------------------------------------
module trc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [trc_pkg::PROD_W-1:0]  num_i,
  input  logic [trc_pkg::PANEL_W-1:0] den_i,
  output logic                        done_o,
  output logic [trc_pkg::PROD_W-1:0]  quo_o
);
  import trc_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [PANEL_W-1:0] rem_q, rem_d;
  logic [PROD_W-1:0]  quo_q, quo_d;
  logic [PANEL_W-1:0] den_q, den_d;
  logic [PANEL_W:0]   shifted;
  logic [PANEL_W:0]   diff;
  logic               ge;

  always_comb begin
    shifted = {rem_q, quo_q[PROD_W-1]};
    diff    = shifted - {1'b0, den_q};
    ge      = shifted >= {1'b0, den_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[PANEL_W-1:0] : shifted[PANEL_W-1:0];
      quo_d = {quo_q[PROD_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(PROD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: hw/rtl/trc_dp.sv
// ----------------------------------------------------------------------------
// trc_dp
// Datapath: item latch, scaling, touch state, pending events, output register.
// ----------------------------------------------------------------------------
module trc_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  trc_pkg::cmd_t               cmd_i,
  output trc_pkg::sts_t               sts_o,
  input  logic                        func_i,
  input  logic                        read_ok_i,
  input  logic [trc_pkg::CNTT_W-1:0]  touch_count_i,
  input  logic [trc_pkg::RAW_W-1:0]   raw_x_i,
  input  logic [trc_pkg::RAW_W-1:0]   raw_y_i,
  input  logic [trc_pkg::DISP_W-1:0]  disp_w_i,
  input  logic [trc_pkg::DISP_W-1:0]  disp_h_i,
  input  logic [trc_pkg::PANEL_W-1:0] panel_w_i,
  input  logic [trc_pkg::PANEL_W-1:0] panel_h_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [trc_pkg::KIND_W-1:0]  event_kind_o,
  output logic [trc_pkg::DISP_W-1:0]  pos_x_o,
  output logic [trc_pkg::DISP_W-1:0]  pos_y_o,
  output logic                        last_o
);
  import trc_pkg::*;

  // item latch
  logic              func_q, read_ok_q;
  logic [CNTT_W-1:0] count_q;
  logic [RAW_W-1:0]  raw_x_q, raw_y_q;

  // touch state
  logic              touching_q, touching_d;
  logic [DISP_W-1:0] last_x_q, last_x_d;
  logic [DISP_W-1:0] last_y_q, last_y_d;
  logic [ERR_W-1:0]  err_q, err_d;
  logic              stopped_q, stopped_d;

  // pending events: slot 0 is finger up at last position, slot 1 down or stop
  logic              ev0_v_q, ev0_v_d;
  logic              ev1_v_q, ev1_v_d;
  event_kind_e       ev1_kind_q, ev1_kind_d;
  logic [DISP_W-1:0] ev1_x_q, ev1_x_d;
  logic [DISP_W-1:0] ev1_y_q, ev1_y_d;

  logic [DISP_W-1:0] sx_q;

  logic              out_valid_q, out_valid_d;
  event_kind_e       out_kind_q, out_kind_d;
  logic [DISP_W-1:0] out_x_q, out_x_d;
  logic [DISP_W-1:0] out_y_q, out_y_d;
  logic              out_last_q, out_last_d;

  logic [RAW_W-1:0]   coord;
  logic [DISP_W-1:0]  disp_sel;
  logic [PROD_W-1:0]  num;
  logic [PANEL_W-1:0] den;
  logic               div_done;
  logic [PROD_W-1:0]  quo;
  logic [DISP_W-1:0]  sy;
  logic [ERR_W-1:0]   err_inc;
  logic               moved;
  logic               out_free;

  assign coord    = (cmd_i.sel_y ? raw_y_q : raw_x_q) & RAW_MASK;
  assign disp_sel = cmd_i.sel_y ? disp_h_i : disp_w_i;
  assign num      = PROD_W'(coord) * PROD_W'(disp_sel);
  assign den      = cmd_i.sel_y ? panel_h_i : panel_w_i;

  trc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign sy       = clamp_axis(quo, disp_h_i);
  assign err_inc  = (err_q == ERR_MAX) ? err_q : err_q + ERR_W'(1);
  assign moved    = !touching_q || (sx_q != last_x_q) || (sy != last_y_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    touching_d  = touching_q;
    last_x_d    = last_x_q;
    last_y_d    = last_y_q;
    err_d       = err_q;
    stopped_d   = stopped_q;
    ev0_v_d     = ev0_v_q;
    ev1_v_d     = ev1_v_q;
    ev1_kind_d  = ev1_kind_q;
    ev1_x_d     = ev1_x_q;
    ev1_y_d     = ev1_y_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    out_kind_d  = out_kind_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_last_d  = out_last_q;

    if (cmd_i.restart) begin
      stopped_d = 1'b0;
    end
    if (cmd_i.fail) begin
      ev0_v_d    = touching_q;
      touching_d = 1'b0;
      err_d      = err_inc;
      ev1_v_d    = 1'b0;
      ev1_kind_d = EV_STOP;
      ev1_x_d    = '0;
      ev1_y_d    = '0;
      if (err_inc >= ERR_LIMIT_V) begin
        stopped_d = 1'b1;
        ev1_v_d   = 1'b1;
      end
    end
    if (cmd_i.lift) begin
      err_d      = '0;
      ev0_v_d    = touching_q;
      touching_d = 1'b0;
      ev1_v_d    = 1'b0;
    end
    if (cmd_i.touch) begin
      err_d      = '0;
      ev0_v_d    = 1'b0;
      ev1_v_d    = moved;
      ev1_kind_d = EV_DOWN;
      ev1_x_d    = sx_q;
      ev1_y_d    = sy;
      if (moved) begin
        touching_d = 1'b1;
        last_x_d   = sx_q;
        last_y_d   = sy;
      end
    end
    if (cmd_i.emit0) begin
      out_valid_d = 1'b1;
      out_kind_d  = EV_UP;
      out_x_d     = last_x_q;
      out_y_d     = last_y_q;
      out_last_d  = !ev1_v_q;
      ev0_v_d     = 1'b0;
    end
    if (cmd_i.emit1) begin
      out_valid_d = 1'b1;
      out_kind_d  = ev1_kind_q;
      out_x_d     = ev1_x_q;
      out_y_d     = ev1_y_q;
      out_last_d  = 1'b1;
      ev1_v_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touching_q  <= 1'b0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      err_q       <= '0;
      stopped_q   <= 1'b0;
      ev0_v_q     <= 1'b0;
      ev1_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      touching_q  <= touching_d;
      last_x_q    <= last_x_d;
      last_y_q    <= last_y_d;
      err_q       <= err_d;
      stopped_q   <= stopped_d;
      ev0_v_q     <= ev0_v_d;
      ev1_v_q     <= ev1_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q    <= func_i;
      read_ok_q <= read_ok_i;
      count_q   <= touch_count_i;
      raw_x_q   <= raw_x_i;
      raw_y_q   <= raw_y_i;
    end
    if (cmd_i.save_x) begin
      sx_q <= clamp_axis(quo, disp_w_i);
    end
    ev1_kind_q <= ev1_kind_d;
    ev1_x_q    <= ev1_x_d;
    ev1_y_q    <= ev1_y_d;
    out_kind_q <= out_kind_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_last_q <= out_last_d;
  end

  always_comb begin
    sts_o.func       = func_q;
    sts_o.stopped    = stopped_q;
    sts_o.read_ok    = read_ok_q;
    sts_o.count_zero = (count_q == '0);
    sts_o.div_done   = div_done;
    sts_o.ev0_v      = ev0_v_q;
    sts_o.ev1_v      = ev1_v_q;
    sts_o.out_free   = out_free;
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = out_kind_q;
  assign pos_x_o      = out_x_q;
  assign pos_y_o      = out_y_q;
  assign last_o       = out_last_q;

endmodule

// File: hw/rtl/trc_ctrl.sv
// ----------------------------------------------------------------------------
// trc_ctrl
// Sequencer: accepts an item, picks its case, runs both axis divides for a touch, emits.
// ----------------------------------------------------------------------------
module trc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  trc_pkg::sts_t sts_i,
  output trc_pkg::cmd_t cmd_o
);
  import trc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts_i.func) begin
          cmd_o.restart = 1'b1;
          state_d       = ST_IDLE;
        end else if (sts_i.stopped) begin
          state_d = ST_IDLE;
        end else if (!sts_i.read_ok) begin
          cmd_o.fail = 1'b1;
          state_d    = ST_EMIT;
        end else if (sts_i.count_zero) begin
          cmd_o.lift = 1'b1;
          state_d    = ST_EMIT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV_X;
        end
      end
      ST_DIV_X: begin
        if (sts_i.div_done) begin
          cmd_o.save_x    = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.sel_y     = 1'b1;
          state_d         = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (sts_i.div_done) begin
          cmd_o.touch = 1'b1;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.ev0_v) begin
          cmd_o.emit0 = sts_i.out_free;
        end else if (sts_i.ev1_v) begin
          cmd_o.emit1 = sts_i.out_free;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/touch_report_conditioner_top.sv
// ----------------------------------------------------------------------------
// touch_report_conditioner_top: finger up/down/stop events from touch polls.
// Touch with a count: the event follows two 22-step divides, one per axis;
// the next item is accepted once that event, if any, has been emitted.
// Failed read or lift: any up or stop event is emitted before the next item.
// Restart or ignored poll: no event; the block returns to idle for the next item.
// Output stalls hold the block in its emit state; one item at a time.
// Async active-low reset: idle, not touching, error count 0, default geometry.
// ----------------------------------------------------------------------------
module touch_report_conditioner_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [trc_pkg::APB_AW-1:0]  paddr,
  input  logic [trc_pkg::APB_DW-1:0]  pwdata,
  output logic [trc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        func_i,
  input  logic                        read_ok_i,
  input  logic [trc_pkg::CNTT_W-1:0]  touch_count_i,
  input  logic [trc_pkg::RAW_W-1:0]   raw_x_i,
  input  logic [trc_pkg::RAW_W-1:0]   raw_y_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [trc_pkg::KIND_W-1:0]  event_kind_o,
  output logic [trc_pkg::DISP_W-1:0]  pos_x_o,
  output logic [trc_pkg::DISP_W-1:0]  pos_y_o,
  output logic                        last_o
);
  import trc_pkg::*;

  logic [DISP_W-1:0]  disp_w_q, disp_h_q;
  logic [PANEL_W-1:0] panel_w_q, panel_h_q;
  logic [1:0]         reg_idx;
  logic               wr_en;
  cmd_t               cmd;
  sts_t               sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_w_q  <= DISP_W_RST;
      disp_h_q  <= DISP_H_RST;
      panel_w_q <= PANEL_W_RST;
      panel_h_q <= PANEL_H_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DISP_W:  disp_w_q  <= pwdata[DISP_W-1:0];
        REG_DISP_H:  disp_h_q  <= pwdata[DISP_W-1:0];
        REG_PANEL_W: panel_w_q <= pwdata[PANEL_W-1:0];
        REG_PANEL_H: panel_h_q <= pwdata[PANEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DISP_W:  prdata = APB_DW'(disp_w_q);
      REG_DISP_H:  prdata = APB_DW'(disp_h_q);
      REG_PANEL_W: prdata = APB_DW'(panel_w_q);
      REG_PANEL_H: prdata = APB_DW'(panel_h_q);
      default:     prdata = '0;
    endcase
  end

  trc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  trc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .func_i        (func_i),
    .read_ok_i     (read_ok_i),
    .touch_count_i (touch_count_i),
    .raw_x_i       (raw_x_i),
    .raw_y_i       (raw_y_i),
    .disp_w_i      (disp_w_q),
    .disp_h_i      (disp_h_q),
    .panel_w_i     (panel_w_q),
    .panel_h_i     (panel_h_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_kind_o  (event_kind_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .last_o        (last_o)
  );

`ifndef SYNTH
  a_stop_at_origin_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == EV_STOP) |-> (pos_x_o == '0) && (pos_y_o == '0) && last_o)
    else $error("stop event must be last and at origin");

  a_down_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == EV_DOWN) |-> last_o)
    else $error("finger down must be the only result of its item");

  a_down_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == EV_DOWN) |->
      ((pos_x_o < disp_w_q) || (pos_x_o == '0)) && ((pos_y_o < disp_h_q) || (pos_y_o == '0)))
    else $error("finger down position outside display");
`endif

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: touch_report_conditioner_top regression
// Random-burst poll items over valid/ready against a behavioral predictor of
// the finger up/down/stop events; geometry changes over APB between phases,
// with readback. Includes directed corners, an error-count saturation storm
// and a long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb;
  import trc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 64;
  localparam int HOLD_AT     = 80;
  localparam int HOLD_CYCLES = 600;

  localparam logic FUNC_POLL    = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  localparam int RX_FREE   = 0;
  localparam int RX_COIN   = 1;
  localparam int RX_BURSTY = 2;

  typedef struct packed {
    logic              func;
    logic              read_ok;
    logic [CNTT_W-1:0] cnt;
    logic [RAW_W-1:0]  rx;
    logic [RAW_W-1:0]  ry;
  } poll_t;

  typedef struct {
    event_kind_e       kind;
    logic [DISP_W-1:0] x;
    logic [DISP_W-1:0] y;
    logic              last;
  } touch_event_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic func_i = 1'b0;
  logic read_ok_i = 1'b0;
  logic [CNTT_W-1:0] touch_count_i = '0;
  logic [RAW_W-1:0] raw_x_i = '0;
  logic [RAW_W-1:0] raw_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [KIND_W-1:0] event_kind_o;
  logic [DISP_W-1:0] pos_x_o;
  logic [DISP_W-1:0] pos_y_o;
  logic last_o;

  touch_report_conditioner_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .read_ok_i     (read_ok_i),
    .touch_count_i (touch_count_i),
    .raw_x_i       (raw_x_i),
    .raw_y_i       (raw_y_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_kind_o  (event_kind_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .last_o        (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state and geometry shadow
  logic [DISP_W-1:0]  cfg_disp_w  = DISP_W_RST;
  logic [DISP_W-1:0]  cfg_disp_h  = DISP_H_RST;
  logic [PANEL_W-1:0] cfg_panel_w = PANEL_W_RST;
  logic [PANEL_W-1:0] cfg_panel_h = PANEL_H_RST;
  logic               touching = 1'b0;
  logic [DISP_W-1:0]  last_x = '0;
  logic [DISP_W-1:0]  last_y = '0;
  logic [ERR_W-1:0]   err_cnt = '0;
  logic               halted = 1'b0;

  poll_t        poll_queue[$];
  touch_event_t pending_events[$];

  int items_queued = 0;
  int in_acc_cnt = 0;
  int in_offer_cnt = 0;
  int events_checked = 0;
  int kind_seen[3] = '{0, 0, 0};
  int mismatch_cnt = 0;
  int cfg_settings = 0;
  int cycle_cnt = 0;
  int burst_left = 0;
  int gap_left = 0;
  int rx_mode = RX_FREE;
  int mode_left = 0;
  int stall_left = 0;
  logic hold_off = 1'b0;

  task automatic flag_mismatch(input string msg);
    mismatch_cnt++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic logic [DISP_W-1:0] scaled_coord(input logic [RAW_W-1:0] raw,
                                                     input logic [DISP_W-1:0] disp,
                                                     input logic [PANEL_W-1:0] panel);
    logic [31:0] coord;
    logic [31:0] q;
    logic [31:0] bound;
    coord = 32'(raw & RAW_MASK);
    if (panel == '0) q = '1;
    else q = (coord * 32'(disp)) / 32'(panel);
    bound = (disp == '0) ? 32'd0 : 32'(disp) - 32'd1;
    if (q > bound) q = bound;
    return q[DISP_W-1:0];
  endfunction

  task automatic predict_events(input poll_t p);
    touch_event_t evs[$];
    logic [DISP_W-1:0] nx;
    logic [DISP_W-1:0] ny;
    if (p.func == FUNC_RESTART) begin
      halted = 1'b0;
      return;
    end
    if (halted) return;
    if (!p.read_ok) begin
      if (touching) begin
        evs.push_back('{kind: EV_UP, x: last_x, y: last_y, last: 1'b0});
        touching = 1'b0;
      end
      if (err_cnt != ERR_MAX) err_cnt++;
      if (err_cnt >= ERR_LIMIT_V) begin
        halted = 1'b1;
        evs.push_back('{kind: EV_STOP, x: '0, y: '0, last: 1'b0});
      end
    end else begin
      err_cnt = '0;
      if (p.cnt == '0) begin
        if (touching) begin
          evs.push_back('{kind: EV_UP, x: last_x, y: last_y, last: 1'b0});
          touching = 1'b0;
        end
      end else begin
        nx = scaled_coord(p.rx, cfg_disp_w, cfg_panel_w);
        ny = scaled_coord(p.ry, cfg_disp_h, cfg_panel_h);
        if (!touching || nx != last_x || ny != last_y) begin
          evs.push_back('{kind: EV_DOWN, x: nx, y: ny, last: 1'b0});
          touching = 1'b1;
          last_x = nx;
          last_y = ny;
        end
      end
    end
    if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
    foreach (evs[i]) pending_events.push_back(evs[i]);
  endtask

  // input side: bursts with random gaps
  always @(negedge clk_i) begin
    poll_t p;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_acc_cnt == in_offer_cnt) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (poll_queue.size() > 0) begin
        p = poll_queue.pop_front();
        func_i        <= p.func;
        read_ok_i     <= p.read_ok;
        touch_count_i <= p.cnt;
        raw_x_i       <= p.rx;
        raw_y_i       <= p.ry;
        in_valid_i    <= 1'b1;
        in_offer_cnt  <= in_offer_cnt + 1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 70);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output side: stall pattern, modes change now and then
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= $urandom_range(RX_FREE, RX_BURSTY);
        mode_left <= $urandom_range(50, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left  <= stall_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE: out_ready_i <= 1'b1;
          RX_COIN: out_ready_i <= 1'($urandom_range(0, 1));
          default: begin
            if ($urandom_range(0, 7) == 0) begin
              stall_left  <= $urandom_range(1, 20);
              out_ready_i <= 1'b0;
            end else begin
              out_ready_i <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    while (in_acc_cnt < HOLD_AT) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_events('{func: func_i, read_ok: read_ok_i, cnt: touch_count_i,
                       rx: raw_x_i, ry: raw_y_i});
      in_acc_cnt <= in_acc_cnt + 1;
    end
  end

  always @(posedge clk_i) begin
    touch_event_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      events_checked++;
      if (event_kind_o < 3) kind_seen[event_kind_o]++;
      if (pending_events.size() == 0) begin
        flag_mismatch($sformatf("unexpected event kind %0d x %0d y %0d last %0b",
                                event_kind_o, pos_x_o, pos_y_o, last_o));
      end else begin
        want = pending_events.pop_front();
        if (event_kind_o !== want.kind || pos_x_o !== want.x || pos_y_o !== want.y ||
            last_o !== want.last) begin
          flag_mismatch($sformatf(
            "event %0d: got kind %0d x %0d y %0d last %0b, want kind %0d x %0d y %0d last %0b",
            events_checked, event_kind_o, pos_x_o, pos_y_o, last_o,
            want.kind, want.x, want.y, want.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events still due", cycle_cnt,
               pending_events.size());
      $display("touch_report_conditioner_top regression: fail");
      $finish;
    end
  end

  task automatic add_item(input logic func, input logic ok, input logic [CNTT_W-1:0] cnt,
                          input logic [RAW_W-1:0] rx, input logic [RAW_W-1:0] ry);
    poll_queue.push_back('{func: func, read_ok: ok, cnt: cnt, rx: rx, ry: ry});
    items_queued++;
  endtask

  task automatic wait_idle();
    while (poll_queue.size() != 0 || in_acc_cnt != items_queued ||
           pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] mask;
    mask = (idx == REG_DISP_W || idx == REG_DISP_H) ? 32'h3FF : 32'hFFF;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_DISP_W:  cfg_disp_w  = val[DISP_W-1:0];
      REG_DISP_H:  cfg_disp_h  = val[DISP_W-1:0];
      REG_PANEL_W: cfg_panel_w = val[PANEL_W-1:0];
      default:     cfg_panel_h = val[PANEL_W-1:0];
    endcase
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((prdata & mask) != (val & mask))
      flag_mismatch($sformatf("reg %0d readback %0h, wrote %0h", idx, prdata, val & mask));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_geometry(input int dw, input int dh, input int pw, input int ph);
    wait_idle();
    apb_write(REG_DISP_W, 32'(dw));
    apb_write(REG_DISP_H, 32'(dh));
    apb_write(REG_PANEL_W, 32'(pw));
    apb_write(REG_PANEL_H, 32'(ph));
    cfg_settings++;
  endtask

  // mostly touch strokes with drift and repeats, plus failure runs and noise
  task automatic gen_random(input int n);
    int made;
    int len;
    int pick;
    logic [RAW_W-1:0] rx;
    logic [RAW_W-1:0] ry;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        if ($urandom_range(0, 3) == 0) begin
          add_item(FUNC_RESTART, 1'($urandom), 4'($urandom), 12'($urandom), 12'($urandom));
          made++;
        end
        rx  = 12'($urandom);
        ry  = 12'($urandom);
        len = $urandom_range(1, 8);
        repeat (len) begin
          add_item(FUNC_POLL, 1'b1, 4'($urandom_range(1, 15)), rx, ry);
          made++;
          case ($urandom_range(0, 3))
            0: ;
            1: begin
              rx = 12'($urandom);
              ry = 12'($urandom);
            end
            default: begin
              rx = rx + 12'($urandom_range(0, 80)) - 12'd40;
              ry = ry + 12'($urandom_range(0, 80)) - 12'd40;
            end
          endcase
        end
        if ($urandom_range(0, 4) != 0)
          add_item(FUNC_POLL, 1'b1, '0, 12'($urandom), 12'($urandom));
        else
          add_item(FUNC_POLL, 1'b0, 4'($urandom), 12'($urandom), 12'($urandom));
        made++;
      end else if (pick < 75) begin
        len = $urandom_range(1, 7);
        repeat (len) begin
          add_item(FUNC_POLL, 1'b0, 4'($urandom), 12'($urandom), 12'($urandom));
          made++;
        end
        if ($urandom_range(0, 1) == 0)
          add_item(FUNC_POLL, 1'($urandom), 4'($urandom), 12'($urandom), 12'($urandom));
        if ($urandom_range(0, 6) != 0) begin
          add_item(FUNC_RESTART, 1'($urandom), 4'($urandom), 12'($urandom), 12'($urandom));
          made++;
        end
      end else if (pick < 90) begin
        add_item(($urandom_range(0, 7) == 0) ? FUNC_RESTART : FUNC_POLL, 1'($urandom),
                 4'($urandom), 12'($urandom), 12'($urandom));
        made++;
      end else begin
        add_item(FUNC_POLL, 1'b1, '0, 12'($urandom), 12'($urandom));
        made++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset geometry
    add_item(FUNC_RESTART, 1'b0, 4'd0, 12'd0, 12'd0);
    add_item(FUNC_POLL, 1'b1, 4'd1, 12'd0, 12'd0);
    add_item(FUNC_POLL, 1'b1, 4'd1, 12'd0, 12'd0);
    add_item(FUNC_POLL, 1'b1, 4'd15, 12'hFFF, 12'hFFF);
    add_item(FUNC_POLL, 1'b1, 4'd3, 12'hFFF, 12'hFFF);
    add_item(FUNC_POLL, 1'b1, 4'd2, 12'd100, 12'd200);
    add_item(FUNC_POLL, 1'b1, 4'd2, 12'd101, 12'd201);
    add_item(FUNC_POLL, 1'b1, 4'd0, 12'd5, 12'd5);
    add_item(FUNC_POLL, 1'b1, 4'd0, 12'hFFF, 12'hFFF);
    add_item(FUNC_POLL, 1'b1, 4'd1, 12'd2048, 12'd1024);
    add_item(FUNC_POLL, 1'b0, 4'd5, 12'hABC, 12'h123);
    repeat (4) add_item(FUNC_POLL, 1'b0, 4'd15, 12'hFFF, 12'hFFF);
    add_item(FUNC_POLL, 1'b1, 4'd1, 12'd300, 12'd300);
    add_item(FUNC_POLL, 1'b0, 4'd0, 12'd0, 12'd0);
    add_item(FUNC_RESTART, 1'b1, 4'd15, 12'hFFF, 12'hFFF);
    add_item(FUNC_POLL, 1'b0, 4'd0, 12'd0, 12'd0);
    add_item(FUNC_RESTART, 1'b0, 4'd0, 12'd0, 12'd0);
    add_item(FUNC_POLL, 1'b1, 4'd0, 12'd0, 12'd0);
    add_item(FUNC_POLL, 1'b1, 4'd8, 12'd2047, 12'd2047);
    add_item(FUNC_POLL, 1'b0, 4'd0, 12'd0, 12'd0);
    add_item(FUNC_POLL, 1'b1, 4'd1, 12'hFFF, 12'd0);
    add_item(FUNC_POLL, 1'b1, 4'd1, 12'd0, 12'hFFF);
    add_item(FUNC_POLL, 1'b1, 4'd0, 12'hFFF, 12'hFFF);

    gen_random(120);

    // failure storm: drives the error count into saturation
    repeat (260) begin
      add_item(FUNC_POLL, 1'b0, 4'($urandom), 12'($urandom), 12'($urandom));
      add_item(FUNC_RESTART, 1'($urandom), 4'($urandom), 12'($urandom), 12'($urandom));
    end
    add_item(FUNC_POLL, 1'b1, 4'd0, 12'd0, 12'd0);
    gen_random(30);

    set_geometry(1023, 1023, 4095, 4095);
    gen_random(120);
    set_geometry(1, 1, 1, 1);
    gen_random(50);
    set_geometry(1023, 1023, 1, 1);
    gen_random(70);
    // zero geometry: all-ones quotient and zero clamp bound
    set_geometry(0, 0, 0, 0);
    gen_random(30);
    repeat (3) begin
      set_geometry($urandom_range(1, 1023), $urandom_range(1, 1023),
                   $urandom_range(1, 4095), $urandom_range(1, 4095));
      gen_random(80);
    end
    set_geometry(200, 228, 390, 450);
    gen_random(80);

    wait_idle();
    $display("ran %0d items over %0d geometry settings plus reset geometry", in_acc_cnt,
             cfg_settings);
    $display("checked %0d events: %0d up, %0d down, %0d stop", events_checked,
             kind_seen[EV_UP], kind_seen[EV_DOWN], kind_seen[EV_STOP]);
    if (mismatch_cnt == 0) begin
      $display("touch_report_conditioner_top regression: pass");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("touch_report_conditioner_top regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/trc_pkg.sv
hw/rtl/trc_div.sv
hw/rtl/trc_dp.sv
hw/rtl/trc_ctrl.sv
hw/rtl/touch_report_conditioner_top.sv
test/tb.sv
